### hw/rtl/q2e_pkg.sv
// shared types, constants and arctangent table for the quaternion to euler unit
`default_nettype none
package q2e_pkg;
   localparam int CordicSteps = 16;
   localparam int TableLen = 24;
   localparam int PathW = 40;
   localparam int AngW = 34;
   localparam int SqrtSteps = 31;
   localparam logic [33:0] PiQ30 = 34'd3373259426;
   localparam logic signed [15:0] PiQ13 = 16'sd25736;
   localparam logic [14:0] DegK = 15'd29335;
   localparam logic [0:0] CsrGimbal = 1'b0;
   localparam logic [0:0] CsrSnap = 1'b1;

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic               item_selected;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] angle_x_deg;
      logic signed [15:0] angle_y_deg;
      logic signed [15:0] angle_z_deg;
      logic               gimbal_hit;
      logic               no_selection;
   } rsp_word_type;

   // one cordic vector in flight
   typedef struct packed {
      logic signed [PathW-1:0] x;
      logic signed [PathW-1:0] y;
      logic signed [AngW-1:0]  z;
      logic                    zero;
   } vec_type;

   // side data that travels along the pipe
   typedef struct packed {
      logic               sel;
      logic               m12_pos;
      logic               m31_pos;
      logic               gimbal;
   } side_type;

   function automatic logic [29:0] atan_entry(input int i);
      logic [29:0] t;
      case (i)
         0: t = 30'h3243F6A8; 1: t = 30'h1DAC6705; 2: t = 30'h0FADBAFC;
         3: t = 30'h07F56EA6; 4: t = 30'h03FEAB76; 5: t = 30'h01FFD55B;
         6: t = 30'h00FFFAAA; 7: t = 30'h007FFF55; 8: t = 30'h003FFFEA;
         9: t = 30'h001FFFFD; 10: t = 30'h000FFFFF; 11: t = 30'h0007FFFF;
         12: t = 30'h0003FFFF; 13: t = 30'h0001FFFF; 14: t = 30'h0000FFFF;
         15: t = 30'h00007FFF; 16: t = 30'h00003FFF; 17: t = 30'h00001FFF;
         18: t = 30'h00000FFF; 19: t = 30'h000007FF; 20: t = 30'h000003FF;
         21: t = 30'h000001FF; 22: t = 30'h000000FF; 23: t = 30'h0000007F;
         default: t = 30'h0;
      endcase
      return t;
   endfunction
endpackage
`default_nettype wire

### hw/rtl/q2e_cordic_stage.sv
// one registered cordic vectoring iteration for three vectors
`default_nettype none
module q2e_cordic_stage
   import q2e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       enable,
   input  wire logic [4:0] stage_idx,
   input  wire vec_type    vec_in [3],
   output vec_type         vec_out [3]
);
   vec_type vec_ff [3];
   vec_type vec_in_n [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vec_in_n[k] = vec_in[k];
         if (int'(stage_idx) < TableLen) begin
            if (vec_in[k].y > 0) begin
               vec_in_n[k].x = vec_in[k].x + (vec_in[k].y >>> stage_idx);
               vec_in_n[k].y = vec_in[k].y - (vec_in[k].x >>> stage_idx);
               vec_in_n[k].z = vec_in[k].z + AngW'(atan_entry(int'(stage_idx)));
            end else begin
               vec_in_n[k].x = vec_in[k].x - (vec_in[k].y >>> stage_idx);
               vec_in_n[k].y = vec_in[k].y + (vec_in[k].x >>> stage_idx);
               vec_in_n[k].z = vec_in[k].z - AngW'(atan_entry(int'(stage_idx)));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) vec_ff <= vec_in_n;
   end
   assign vec_out = vec_ff;
endmodule
`default_nettype wire

### hw/rtl/q2e_sqrt_stage.sv
// one registered digit of the integer square root
`default_nettype none
module q2e_sqrt_stage
   import q2e_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [4:0]  stage_idx,
   input  wire logic [61:0] rem_in,
   input  wire logic [30:0] root_in,
   output logic      [61:0] rem_out,
   output logic      [30:0] root_out
);
   logic [5:0] sh;
   logic [61:0] rem_ff;
   logic [30:0] root_ff;
   logic [63:0] trial;

   // digit weight is two bits per stage, msb first
   assign sh = 6'(2 * (SqrtSteps - 1)) - {stage_idx, 1'b0};

   // root_in holds upper bits; trial = (root<<2 | 1) << sh
   assign trial = ({31'd0, root_in, 2'b01}) << sh;

   always_ff @(posedge clock) begin
      if (enable) begin
         if ({2'b00, rem_in} >= trial) begin
            rem_ff <= rem_in - trial[61:0];
            root_ff <= {root_in[29:0], 1'b1};
         end else begin
            rem_ff <= rem_in;
            root_ff <= {root_in[29:0], 1'b0};
         end
      end
   end
   assign rem_out = rem_ff;
   assign root_out = root_ff;
endmodule
`default_nettype wire

### hw/rtl/quaternion_to_euler_degrees_unit.sv
// top level: quaternion to euler angles in 1/64 degree, fully pipelined
// req_ channel takes one quaternion word per cycle (valid/ready); rsp_ returns one
// word per request in order. csr_ writes gimbal_cos_limit (index 0) and
// zero_snap_limit (index 1); write only while the pipe is empty.
// depth: 52 register stages (2 + 31 + 16 + 3); rsp_valid is the last bit of the
// valid shift register that req_valid enters at the accepting edge.
// throughput: one word per cycle unless stalled; the 31-step square root and the 16-step
// cordic are unrolled into registered stages, one digit or iteration each.
// stall: the whole pipe holds when the output register is full and not taken;
// req_ready is low only then, so nothing is lost or repeated.
// reset clears all valid bits and sets both limits to 1.
`default_nettype none
module quaternion_to_euler_degrees_unit
   import q2e_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_write,
   input  wire logic [0:0]   csr_index,
   input  wire logic [14:0]  csr_data
);
   localparam int Depth = 2 + SqrtSteps + CordicSteps + 3;

   logic [14:0] gimbal_lim_ff;
   logic [12:0] snap_lim_ff;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;
   logic advance;

   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         gimbal_lim_ff <= 15'd1;
         snap_lim_ff <= 13'd1;
      end else if (csr_write) begin
         case (csr_index)
            CsrGimbal: gimbal_lim_ff <= csr_data;
            CsrSnap: snap_lim_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   assign vld_in = {vld_ff[Depth-2:0], req_valid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end
   assign rsp_valid = vld_ff[Depth-1];

   // stage 1: products
   logic signed [31:0] p_xy_ff, p_zw_ff, p_xx_ff, p_zz_ff, p_xz_ff, p_yw_ff;
   logic signed [31:0] p_yz_ff, p_xw_ff, p_yy_ff;
   logic sel1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         p_xy_ff <= req_word.quat_x * req_word.quat_y;
         p_zw_ff <= req_word.quat_z * req_word.quat_w;
         p_xx_ff <= req_word.quat_x * req_word.quat_x;
         p_zz_ff <= req_word.quat_z * req_word.quat_z;
         p_xz_ff <= req_word.quat_x * req_word.quat_z;
         p_yw_ff <= req_word.quat_y * req_word.quat_w;
         p_yz_ff <= req_word.quat_y * req_word.quat_z;
         p_xw_ff <= req_word.quat_x * req_word.quat_w;
         p_yy_ff <= req_word.quat_y * req_word.quat_y;
         sel1_ff <= req_word.item_selected;
      end
   end

   // stage 2: matrix terms and clamped sine
   logic signed [35:0] m12_in, m22_in, m31_in, m32_in, m33_in, s_in;
   logic signed [35:0] m12_ff, m22_ff, m31_ff, m33_ff, s_ff;
   logic sel2_ff;
   localparam logic signed [35:0] One30 = 36'sd1073741824;
   always_comb begin
      m12_in = 36'(p_xy_ff) + 36'(p_zw_ff); m12_in = m12_in <<< 1;
      m22_in = One30 - ((36'(p_xx_ff) + 36'(p_zz_ff)) <<< 1);
      m31_in = (36'(p_xz_ff) + 36'(p_yw_ff)) <<< 1;
      m32_in = (36'(p_yz_ff) - 36'(p_xw_ff)) <<< 1;
      m33_in = One30 - ((36'(p_xx_ff) + 36'(p_yy_ff)) <<< 1);
      s_in = -m32_in;
      if (s_in > One30) s_in = One30;
      if (s_in < -One30) s_in = -One30;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         m12_ff <= m12_in; m22_ff <= m22_in; m31_ff <= m31_in;
         m33_ff <= m33_in; s_ff <= s_in; sel2_ff <= sel1_ff;
      end
   end

   // s is within 31 bits magnitude; square via 31x31 unsigned
   logic [30:0] s_mag;
   logic [61:0] rad;
   assign s_mag = s_ff[35] ? 31'(-s_ff) : s_ff[30:0];
   assign rad = 62'(64'd1 << 60) - (62'(s_mag) * 62'(s_mag));

   // sqrt pipeline, the other terms ride along in delay lines
   logic [61:0] rem_w [SqrtSteps+1];
   logic [30:0] root_w [SqrtSteps+1];
   logic signed [35:0] dly_ff [SqrtSteps][5];
   logic dsel_ff [SqrtSteps];
   assign rem_w[0] = rad;
   assign root_w[0] = '0;
   for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
      q2e_sqrt_stage u_sq (
         .clock(clock), .enable(advance), .stage_idx(5'(g)),
         .rem_in(rem_w[g]), .root_in(root_w[g]),
         .rem_out(rem_w[g+1]), .root_out(root_w[g+1]));
      if (g == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (advance) begin
               dly_ff[0] <= '{m12_ff, m22_ff, m31_ff, m33_ff, s_ff};
               dsel_ff[0] <= sel2_ff;
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (advance) begin
               dly_ff[g] <= dly_ff[g-1];
               dsel_ff[g] <= dsel_ff[g-1];
            end
         end
      end
   end

   // cordic entry: quadrant fold, gimbal compare
   logic signed [35:0] em12, em22, em31, em33, es;
   logic [30:0] c30;
   assign {em12, em22, em31, em33, es} =
      {dly_ff[SqrtSteps-1][0], dly_ff[SqrtSteps-1][1], dly_ff[SqrtSteps-1][2],
       dly_ff[SqrtSteps-1][3], dly_ff[SqrtSteps-1][4]};
   assign c30 = root_w[SqrtSteps];

   function automatic vec_type fold(input logic signed [35:0] y, input logic signed [35:0] x);
      vec_type v;
      v.zero = (x == 0) && (y == 0);
      v.x = PathW'(x); v.y = PathW'(y); v.z = '0;
      if (x < 0) begin
         v.x = -PathW'(x); v.y = -PathW'(y);
         v.z = (y >= 0) ? AngW'(PiQ30) : -AngW'(PiQ30);
      end
      return v;
   endfunction

   vec_type cv [CordicSteps+1][3];
   side_type side_ff [CordicSteps];
   logic [31:0] cos_rnd;
   assign cos_rnd = 32'(c30) + 32'd16384;
   assign cv[0][0] = fold(em12, em22);
   assign cv[0][1] = fold(es, 36'(c30));
   assign cv[0][2] = fold(em31, em33);
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0].sel <= dsel_ff[SqrtSteps-1];
         side_ff[0].m12_pos <= em12 > 0;
         side_ff[0].m31_pos <= em31 > 0;
         side_ff[0].gimbal <= cos_rnd[31:15] < {2'b00, gimbal_lim_ff};
      end
   end
   for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
      q2e_cordic_stage u_cs (
         .clock(clock), .enable(advance), .stage_idx(5'(g)),
         .vec_in(cv[g]), .vec_out(cv[g+1]));
      if (g > 0) begin : g_side
         always_ff @(posedge clock) begin
            if (advance) side_ff[g] <= side_ff[g-1];
         end
      end
   end
   // side_ff[0] is registered with the first cordic stage; the cordic output aligns with index CordicSteps-1
   side_type cs;
   assign cs = side_ff[CordicSteps-1];

   // post 1: round to q13, gimbal offset
   logic signed [16:0] ang_in [3];
   logic signed [16:0] ang_ff [3];
   side_type side_p1_ff, side_p2_ff;
   function automatic logic signed [16:0] rnd17(input logic signed [AngW-1:0] z);
      logic signed [AngW-1:0] m;
      m = z[AngW-1] ? -z : z;
      m = (m + AngW'(1 << 16)) >>> 17;
      return z[AngW-1] ? -17'(m) : 17'(m);
   endfunction
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ang_in[k] = cv[CordicSteps][k].zero ? 17'sd0 : rnd17(cv[CordicSteps][k].z);
      end
      if (cs.gimbal) begin
         ang_in[0] = ang_in[0] + (cs.m12_pos ? 17'(PiQ13) : -17'(PiQ13));
         ang_in[2] = ang_in[2] + (cs.m31_pos ? 17'(PiQ13) : -17'(PiQ13));
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         ang_ff <= ang_in;
         side_p1_ff <= cs;
      end
   end

   // post 2: snap, sign, degree multiply
   logic signed [32:0] deg_in [3];
   logic signed [32:0] deg_ff [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [16:0] a;
         logic [16:0] m;
         a = ang_ff[k];
         m = a[16] ? 17'(-a) : 17'(a);
         if (m < {4'd0, snap_lim_ff}) a = '0;
         if (k != 1) a = -a;
         deg_in[k] = 33'(a) * $signed({1'b0, DegK});
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         deg_ff <= deg_in;
         side_p2_ff <= side_p1_ff;
      end
   end

   // post 3: round, select
   function automatic logic signed [15:0] rnd16(input logic signed [32:0] d);
      logic [32:0] m;
      m = d[32] ? 33'(-d) : 33'(d);
      m = (m + 33'd32768) >> 16;
      return d[32] ? -16'(m) : 16'(m);
   endfunction
   rsp_word_type out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.angle_z_deg <= side_p2_ff.sel ? rnd16(deg_ff[0]) : '0;
         out_ff.angle_x_deg <= side_p2_ff.sel ? rnd16(deg_ff[1]) : '0;
         out_ff.angle_y_deg <= side_p2_ff.sel ? rnd16(deg_ff[2]) : '0;
         out_ff.gimbal_hit <= side_p2_ff.sel & side_p2_ff.gimbal;
         out_ff.no_selection <= !side_p2_ff.sel;
      end
   end
   assign rsp_word = out_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word)) else $error("rsp dropped");
   a_nosel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.no_selection |-> rsp_word.angle_x_deg == 0 && !rsp_word.gimbal_hit)
      else $error("no selection with angle");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("stall without full output");
`endif
endmodule
`default_nettype wire
